FILE: rtl/core/tgn_pkg.sv
`timescale 1ns / 1ps

package tgn_pkg;

  // Fixed input format and tile limits
  localparam int FRAC_BITS  = 16;
  localparam int LG_MIN     = 3;
  localparam int LG_MAX     = 6;     // log2 of the largest tile, 64 cells

  // Fade codes
  localparam logic [1:0] FADE_LINEAR  = 2'd0;
  localparam logic [1:0] FADE_CUBIC   = 2'd1;
  localparam logic [1:0] FADE_POLY5   = 2'd2;

  // Hash multipliers
  localparam logic [31:0] MIX_C1 = 32'h21f0aaad;
  localparam logic [31:0] MIX_C2 = 32'h735a2d97;

  // Pipeline depths
  localparam int SQ_STEPS    = 19;   // root bits of the squared length
  localparam int DIV_STEPS   = 17;   // quotient bits of each component
  localparam int UNIT_LAT    = SQ_STEPS + DIV_STEPS + 4;
  localparam int HASH_LAT    = 7;
  localparam int CORNER_LAT  = HASH_LAT + 2 * UNIT_LAT;
  localparam int FADE_LAT    = 6;
  localparam int TXY_DLY     = CORNER_LAT + 2 - FADE_LAT;

  typedef logic signed [17:0] sin_tab_t [256];

  // Taylor term divisors (2n)(2n+1)
  function automatic logic [63:0] taylor_div(input int n, input logic [63:0] v);
    logic [63:0] r;
    case (n)
      1:       r = v / 64'd6;
      2:       r = v / 64'd20;
      3:       r = v / 64'd42;
      4:       r = v / 64'd72;
      5:       r = v / 64'd110;
      default: r = v / 64'd156;
    endcase
    return r;
  endfunction

  // sin(r * pi / 128) in Q16, r in 0..64, series in Q30
  function automatic logic [16:0] sin_quarter(input int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    x = (64'd3373259426 * 64'(r)) >> 7;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      t = taylor_div(n, (t * x2) >> 30);
      if ((n % 2) == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    s = (s + 8192) >>> 14;
    if (s > 65536) s = 65536;
    return 17'(s);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    int          q;
    int          r;
    logic [16:0] v;
    for (int j = 0; j < 256; j++) begin
      q = (j >> 6) & 3;
      r = j & 63;
      v = ((q & 1) != 0) ? sin_quarter(64 - r) : sin_quarter(r);
      tab[j] = ((q & 2) != 0) ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Drop 16 fraction bits, rounding half away from zero
  function automatic logic signed [23:0] rnd16(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [23:0] q;
    mag = v[39] ? 40'(-v) : 40'(v);
    q = 24'((mag + 40'd32768) >> 16);
    return v[39] ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: rtl/core/tgn_mix.sv
`timescale 1ns / 1ps

// One round of the 32-bit integer hash, two multiplier stages
module tgn_mix import tgn_pkg::*; (
  input  logic        clk,
  input  logic [31:0] in_h,
  output logic [31:0] out_h
);

  logic [31:0] p1_r;
  logic [31:0] p2_r;

  always_ff @(posedge clk) begin
    p1_r <= (in_h ^ 32'($signed(in_h) >>> 16)) * MIX_C1;
    p2_r <= (p1_r ^ 32'($signed(p1_r) >>> 15)) * MIX_C2;
  end

  assign out_h = p2_r ^ 32'($signed(p2_r) >>> 15);

endmodule

FILE: rtl/core/tgn_unit.sv
`timescale 1ns / 1ps

// Scales a vector to unit length in Q16: squares, bit-serial floor root,
// then one restoring quotient bit per stage for each component
module tgn_unit import tgn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [18:0] in_x,
  input  logic signed [18:0] in_y,
  output logic               out_vld,
  output logic signed [17:0] out_x,
  output logic signed [17:0] out_y
);

  logic [17:0] ax_c;
  logic [17:0] ay_c;

  logic [17:0] ax1_r, ay1_r;
  logic        sx1_r, sy1_r;
  logic [35:0] sqx1_r, sqy1_r;

  logic [17:0] ax2_r, ay2_r;
  logic        sx2_r, sy2_r;
  logic [37:0] m2_r;

  // root stages
  logic [18:0] rt_r   [SQ_STEPS];
  logic [20:0] rm_r   [SQ_STEPS];
  logic [37:0] rad_r  [SQ_STEPS];
  logic [17:0] sax_r  [SQ_STEPS];
  logic [17:0] say_r  [SQ_STEPS];
  logic        ssx_r  [SQ_STEPS];
  logic        ssy_r  [SQ_STEPS];
  logic [18:0] rt_nxt [SQ_STEPS];
  logic [20:0] rm_nxt [SQ_STEPS];
  logic [22:0] rs_c   [SQ_STEPS];
  logic [22:0] tr_c   [SQ_STEPS];

  // quotient set-up
  logic [34:0] nx_c, ny_c;
  logic [18:0] mi_r;
  logic [19:0] rxi_r, ryi_r;
  logic [16:0] lxi_r, lyi_r;
  logic        sxi_r, syi_r, zi_r;

  // quotient stages
  logic [18:0] dm_r  [DIV_STEPS];
  logic [19:0] rx_r  [DIV_STEPS];
  logic [19:0] ry_r  [DIV_STEPS];
  logic [16:0] lx_r  [DIV_STEPS];
  logic [16:0] ly_r  [DIV_STEPS];
  logic [16:0] qx_r  [DIV_STEPS];
  logic [16:0] qy_r  [DIV_STEPS];
  logic        dsx_r [DIV_STEPS];
  logic        dsy_r [DIV_STEPS];
  logic        dz_r  [DIV_STEPS];
  logic [19:0] rx_nxt [DIV_STEPS];
  logic [19:0] ry_nxt [DIV_STEPS];
  logic [16:0] qx_nxt [DIV_STEPS];
  logic [16:0] qy_nxt [DIV_STEPS];
  logic [20:0] dsx_c  [DIV_STEPS];
  logic [20:0] dsy_c  [DIV_STEPS];

  logic signed [17:0] ox_r, oy_r;
  logic               vld_r [UNIT_LAT];

  // magnitudes
  assign ax_c = in_x[18] ? 18'(-in_x) : 18'(in_x);
  assign ay_c = in_y[18] ? 18'(-in_y) : 18'(in_y);

  always_ff @(posedge clk) begin
    ax1_r  <= ax_c;
    ay1_r  <= ay_c;
    sx1_r  <= in_x[18];
    sy1_r  <= in_y[18];
    sqx1_r <= ax_c * ax_c;
    sqy1_r <= ay_c * ay_c;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    m2_r   <= 38'(sqx1_r) + 38'(sqy1_r);
  end

  // one root bit per stage
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      rs_c[k] = (k == 0) ? {21'd0, m2_r[37:36]} : {rm_r[k-1], rad_r[k-1][37:36]};
      tr_c[k] = (k == 0) ? 23'd1 : {2'b00, rt_r[k-1], 2'b01};
      if (rs_c[k] >= tr_c[k]) begin
        rm_nxt[k] = 21'(rs_c[k] - tr_c[k]);
        rt_nxt[k] = (k == 0) ? 19'd1 : {rt_r[k-1][17:0], 1'b1};
      end else begin
        rm_nxt[k] = rs_c[k][20:0];
        rt_nxt[k] = (k == 0) ? 19'd0 : {rt_r[k-1][17:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      rt_r[k] <= rt_nxt[k];
      rm_r[k] <= rm_nxt[k];
      if (k == 0) begin
        rad_r[k] <= {m2_r[35:0], 2'b00};
        sax_r[k] <= ax2_r;
        say_r[k] <= ay2_r;
        ssx_r[k] <= sx2_r;
        ssy_r[k] <= sy2_r;
      end else begin
        rad_r[k] <= {rad_r[k-1][35:0], 2'b00};
        sax_r[k] <= sax_r[k-1];
        say_r[k] <= say_r[k-1];
        ssx_r[k] <= ssx_r[k-1];
        ssy_r[k] <= ssy_r[k-1];
      end
    end
  end

  // numerators with half the divisor added for rounding
  assign nx_c = {1'b0, sax_r[SQ_STEPS-1], 16'd0} + {17'd0, rt_r[SQ_STEPS-1][18:1]};
  assign ny_c = {1'b0, say_r[SQ_STEPS-1], 16'd0} + {17'd0, rt_r[SQ_STEPS-1][18:1]};

  always_ff @(posedge clk) begin
    mi_r  <= rt_r[SQ_STEPS-1];
    rxi_r <= {2'b00, nx_c[34:17]};
    ryi_r <= {2'b00, ny_c[34:17]};
    lxi_r <= nx_c[16:0];
    lyi_r <= ny_c[16:0];
    sxi_r <= ssx_r[SQ_STEPS-1];
    syi_r <= ssy_r[SQ_STEPS-1];
    zi_r  <= (rt_r[SQ_STEPS-1] == 19'd0);
  end

  // one quotient bit per stage
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      dsx_c[j] = (j == 0) ? {rxi_r, lxi_r[16]} : {rx_r[j-1], lx_r[j-1][16]};
      dsy_c[j] = (j == 0) ? {ryi_r, lyi_r[16]} : {ry_r[j-1], ly_r[j-1][16]};
      qx_nxt[j] = (j == 0) ? 17'd0 : {qx_r[j-1][15:0], 1'b0};
      qy_nxt[j] = (j == 0) ? 17'd0 : {qy_r[j-1][15:0], 1'b0};
      if (dsx_c[j] >= {2'b00, ((j == 0) ? mi_r : dm_r[j-1])}) begin
        rx_nxt[j] = 20'(dsx_c[j] - {2'b00, ((j == 0) ? mi_r : dm_r[j-1])});
        qx_nxt[j][0] = 1'b1;
      end else begin
        rx_nxt[j] = dsx_c[j][19:0];
      end
      if (dsy_c[j] >= {2'b00, ((j == 0) ? mi_r : dm_r[j-1])}) begin
        ry_nxt[j] = 20'(dsy_c[j] - {2'b00, ((j == 0) ? mi_r : dm_r[j-1])});
        qy_nxt[j][0] = 1'b1;
      end else begin
        ry_nxt[j] = dsy_c[j][19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      rx_r[j] <= rx_nxt[j];
      ry_r[j] <= ry_nxt[j];
      qx_r[j] <= qx_nxt[j];
      qy_r[j] <= qy_nxt[j];
      if (j == 0) begin
        dm_r[j]  <= mi_r;
        lx_r[j]  <= {lxi_r[15:0], 1'b0};
        ly_r[j]  <= {lyi_r[15:0], 1'b0};
        dsx_r[j] <= sxi_r;
        dsy_r[j] <= syi_r;
        dz_r[j]  <= zi_r;
      end else begin
        dm_r[j]  <= dm_r[j-1];
        lx_r[j]  <= {lx_r[j-1][15:0], 1'b0};
        ly_r[j]  <= {ly_r[j-1][15:0], 1'b0};
        dsx_r[j] <= dsx_r[j-1];
        dsy_r[j] <= dsy_r[j-1];
        dz_r[j]  <= dz_r[j-1];
      end
    end
  end

  // sign back on; a zero vector stays zero
  always_ff @(posedge clk) begin
    if (dz_r[DIV_STEPS-1]) begin
      ox_r <= '0;
      oy_r <= '0;
    end else begin
      ox_r <= dsx_r[DIV_STEPS-1] ? -$signed({1'b0, qx_r[DIV_STEPS-1]})
                                 : $signed({1'b0, qx_r[DIV_STEPS-1]});
      oy_r <= dsy_r[DIV_STEPS-1] ? -$signed({1'b0, qy_r[DIV_STEPS-1]})
                                 : $signed({1'b0, qy_r[DIV_STEPS-1]});
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < UNIT_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < UNIT_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_vld = vld_r[UNIT_LAT-1];
  assign out_x   = ox_r;
  assign out_y   = oy_r;

endmodule

FILE: rtl/core/tgn_corner.sv
`timescale 1ns / 1ps

// Gradient of one lattice corner: hash, table lookup, two normalisations
module tgn_corner import tgn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [5:0]         in_cx,
  input  logic [5:0]         in_cy,
  input  logic [2:0]         lg,
  output logic               out_vld,
  output logic signed [17:0] out_gx,
  output logic signed [17:0] out_gy
);

  logic [31:0] hy_c, h1_c, h2_c;
  logic [5:0]  cx_d_r [2];
  logic [31:0] h1_d_r [2];
  logic        hv_r   [HASH_LAT];
  logic [7:0]  mask_c;
  logic [3:0]  step_c;
  logic [7:0]  ia_c, ib_c;
  logic signed [17:0] ux_r, uy_r;
  logic               v1_c;
  logic signed [17:0] u1x_c, u1y_c;
  logic signed [18:0] wx_c, wy_c;

  // hash chain: mix(cx ^ mix(cy)), then mix of that
  tgn_mix u_mix_y (.clk(clk), .in_h({26'd0, in_cy}), .out_h(hy_c));
  tgn_mix u_mix_1 (.clk(clk), .in_h({26'd0, cx_d_r[1]} ^ hy_c), .out_h(h1_c));
  tgn_mix u_mix_2 (.clk(clk), .in_h(h1_c), .out_h(h2_c));

  always_ff @(posedge clk) begin
    cx_d_r[0] <= in_cx;
    cx_d_r[1] <= cx_d_r[0];
    h1_d_r[0] <= h1_c;
    h1_d_r[1] <= h1_d_r[0];
  end

  // table indices on the 256-step circle; cos is a quarter turn ahead
  assign mask_c = 8'((9'd1 << lg) - 9'd1);
  assign step_c = 4'd8 - {1'b0, lg};
  assign ia_c   = 8'((h1_d_r[1][7:0] & mask_c) << step_c) + 8'd64;
  assign ib_c   = 8'((h2_c[7:0] & mask_c) << step_c);

  always_ff @(posedge clk) begin
    ux_r <= SIN_TAB[ia_c];
    uy_r <= SIN_TAB[ib_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HASH_LAT; i++) hv_r[i] <= 1'b0;
    end else begin
      hv_r[0] <= in_vld;
      for (int i = 1; i < HASH_LAT; i++) hv_r[i] <= hv_r[i-1];
    end
  end

  tgn_unit u_unit_1 (
    .clk(clk), .rst_n(rst_n), .in_vld(hv_r[HASH_LAT-1]),
    .in_x({ux_r[17], ux_r}), .in_y({uy_r[17], uy_r}),
    .out_vld(v1_c), .out_x(u1x_c), .out_y(u1y_c)
  );

  // w = 2u - 1
  assign wx_c = $signed({u1x_c, 1'b0}) - 19'sd65536;
  assign wy_c = $signed({u1y_c, 1'b0}) - 19'sd65536;

  tgn_unit u_unit_2 (
    .clk(clk), .rst_n(rst_n), .in_vld(v1_c),
    .in_x(wx_c), .in_y(wy_c),
    .out_vld(out_vld), .out_x(out_gx), .out_y(out_gy)
  );

endmodule

FILE: rtl/core/tgn_fade.sv
`timescale 1ns / 1ps

// Fade curve on a Q16 fraction, computed in a pipeline of registered multiplier stages
module tgn_fade import tgn_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  mode,
  input  logic [15:0] in_t,
  output logic [16:0] out_t
);

  logic [31:0] tt1_r;
  logic [15:0] t1_r, t2b_r, t3b_r, t4_r, t5_r;
  logic [16:0] t2_r;
  logic [34:0] hp3_r;
  logic [32:0] tp3_r;
  logic [19:0] p3_r, p4_r;
  logic [16:0] t3_r;
  logic [17:0] herm4_r, herm5_r;
  logic [36:0] qp5_r;
  logic [21:0] quin_c;
  logic [21:0] sel_c;
  logic [16:0] out_r;

  always_ff @(posedge clk) begin
    // t^2
    tt1_r   <= in_t * in_t;
    t1_r    <= in_t;
    t2_r    <= 17'((33'(tt1_r) + 33'd32768) >> 16);
    t2b_r   <= t1_r;
    // hermite product, t^3 product, quintic polynomial
    hp3_r   <= t2_r * (18'd196608 - {1'b0, t2b_r, 1'b0});
    tp3_r   <= t2_r * t2b_r;
    p3_r    <= 20'(22'(t2_r) * 22'd6 + 22'd655360 - 22'(t2b_r) * 22'd15);
    t3b_r   <= t2b_r;
    t3_r    <= 17'((tp3_r + 33'd32768) >> 16);
    herm4_r <= 18'((36'(hp3_r) + 36'd32768) >> 16);
    p4_r    <= p3_r;
    t4_r    <= t3b_r;
    qp5_r   <= t3_r * p4_r;
    herm5_r <= herm4_r;
    t5_r    <= t4_r;
  end

  assign quin_c = 22'((38'(qp5_r) + 38'd32768) >> 16);

  // select the curve
  always_comb begin
    case (mode)
      FADE_CUBIC: sel_c = {4'd0, herm5_r};
      FADE_POLY5: sel_c = quin_c;
      default:    sel_c = {6'd0, t5_r};
    endcase
  end

  // cap at one
  always_ff @(posedge clk) begin
    out_r <= (sel_c > 22'd65536) ? 17'd65536 : sel_c[16:0];
  end

  assign out_t = out_r;

endmodule

FILE: rtl/core/tileable_gradient_noise_2d.sv
`timescale 1ns / 1ps

// Tileable 2D gradient noise. A sample (in_coord_x, in_coord_y, unsigned
// Q16.16) is taken at every clock edge with start high; busy is always low,
// so a new word may be sent in every cycle. Each sample comes back as
// out_noise_value (signed Q1.16, -65536..65536) with out_valid high for one
// cycle, in order. Most of the pipeline lies in the two normalisation
// pipelines of each corner (19 root stages and 17 quotient stages each),
// which follow the three-round hash. The receiver cannot stall the result.
// Registers: index 0 tile_log2 (values below 3 act as 3, above 6 as 6),
// index 1 fade_mode (0 linear, 1 hermite, 2 quintic, 3 linear); write
// them only while no sample is in flight. cfg_ready is always high.
module tileable_gradient_noise_2d import tgn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_coord_x,
  input  logic [31:0]        in_coord_y,
  output logic               out_valid,
  output logic signed [17:0] out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [2:0]         cfg_data
);

  localparam logic [0:0] CFG_TILE_LOG2 = 1'b0;
  localparam logic [0:0] CFG_FADE_MODE = 1'b1;

  logic [2:0]  tile_log2_r;
  logic [1:0]  fade_mode_r;
  logic        vld_r;
  logic [31:0] x_r, y_r;
  logic [2:0]  lg_c;
  logic [5:0]  mask_c;
  logic [5:0]  cxs_c [4];
  logic [5:0]  cys_c [4];
  logic        gv_c  [4];
  logic signed [17:0] gx_c [4];
  logic signed [17:0] gy_c [4];
  logic [15:0] fx_dly_r [CORNER_LAT];
  logic [15:0] fy_dly_r [CORNER_LAT];
  logic [16:0] tx_c, ty_c;
  logic [16:0] tx_dly_r [TXY_DLY];
  logic [16:0] ty_dly_r [TXY_DLY+2];
  logic signed [16:0] fxp_c, fxn_c, fyp_c, fyn_c;
  logic signed [34:0] px_r [4];
  logic signed [34:0] py_r [4];
  logic signed [18:0] va_r, vb_r, vc_r, vd_r;
  logic signed [17:0] tx_s_c, ctx_c, ty_s_c, cty_c;
  logic signed [36:0] bx0_r, bx1_r, bx2_r, bx3_r;
  logic signed [18:0] lx0_r, lx1_r;
  logic signed [36:0] by0_r, by1_r;
  logic signed [23:0] r_c;
  logic signed [17:0] res_r;
  logic               post_vld_r [6];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_log2_r <= 3'd3;
      fade_mode_r <= FADE_LINEAR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TILE_LOG2: tile_log2_r <= cfg_data;
        CFG_FADE_MODE: fade_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= start;
    if (start) begin
      x_r <= in_coord_x;
      y_r <= in_coord_y;
    end
  end

  // effective tile size and wrapped corners
  assign lg_c = (tile_log2_r < 3'(LG_MIN)) ? 3'(LG_MIN) :
                (tile_log2_r > 3'(LG_MAX)) ? 3'(LG_MAX) : tile_log2_r;
  assign mask_c = 6'((7'd1 << lg_c) - 7'd1);

  assign cxs_c[0] = x_r[FRAC_BITS +: 6] & mask_c;
  assign cxs_c[1] = 6'(x_r[FRAC_BITS +: 6] + 6'd1) & mask_c;
  assign cxs_c[2] = cxs_c[0];
  assign cxs_c[3] = cxs_c[1];
  assign cys_c[0] = y_r[FRAC_BITS +: 6] & mask_c;
  assign cys_c[1] = cys_c[0];
  assign cys_c[2] = 6'(y_r[FRAC_BITS +: 6] + 6'd1) & mask_c;
  assign cys_c[3] = cys_c[2];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    tgn_corner u_corner (
      .clk(clk), .rst_n(rst_n), .in_vld(vld_r),
      .in_cx(cxs_c[c]), .in_cy(cys_c[c]), .lg(lg_c),
      .out_vld(gv_c[c]), .out_gx(gx_c[c]), .out_gy(gy_c[c])
    );
  end

  // fades
  tgn_fade u_fade_x (.clk(clk), .mode(fade_mode_r), .in_t(x_r[FRAC_BITS-1:0]), .out_t(tx_c));
  tgn_fade u_fade_y (.clk(clk), .mode(fade_mode_r), .in_t(y_r[FRAC_BITS-1:0]), .out_t(ty_c));

  // fraction and fade delay lines
  always_ff @(posedge clk) begin
    fx_dly_r[0] <= x_r[FRAC_BITS-1:0];
    fy_dly_r[0] <= y_r[FRAC_BITS-1:0];
    for (int i = 1; i < CORNER_LAT; i++) begin
      fx_dly_r[i] <= fx_dly_r[i-1];
      fy_dly_r[i] <= fy_dly_r[i-1];
    end
    tx_dly_r[0] <= tx_c;
    for (int i = 1; i < TXY_DLY; i++) tx_dly_r[i] <= tx_dly_r[i-1];
    ty_dly_r[0] <= ty_c;
    for (int i = 1; i < TXY_DLY + 2; i++) ty_dly_r[i] <= ty_dly_r[i-1];
  end

  // corner offsets: f and f - 1
  assign fxp_c = $signed({1'b0, fx_dly_r[CORNER_LAT-1]});
  assign fxn_c = $signed({1'b1, fx_dly_r[CORNER_LAT-1]});
  assign fyp_c = $signed({1'b0, fy_dly_r[CORNER_LAT-1]});
  assign fyn_c = $signed({1'b1, fy_dly_r[CORNER_LAT-1]});

  // dot products
  always_ff @(posedge clk) begin
    px_r[0] <= gx_c[0] * fxp_c;
    py_r[0] <= gy_c[0] * fyp_c;
    px_r[1] <= gx_c[1] * fxn_c;
    py_r[1] <= gy_c[1] * fyp_c;
    px_r[2] <= gx_c[2] * fxp_c;
    py_r[2] <= gy_c[2] * fyn_c;
    px_r[3] <= gx_c[3] * fxn_c;
    py_r[3] <= gy_c[3] * fyn_c;
    va_r <= 19'(rnd16(40'(px_r[0]) + 40'(py_r[0])));
    vb_r <= 19'(rnd16(40'(px_r[1]) + 40'(py_r[1])));
    vc_r <= 19'(rnd16(40'(px_r[2]) + 40'(py_r[2])));
    vd_r <= 19'(rnd16(40'(px_r[3]) + 40'(py_r[3])));
  end

  // lerp weights
  assign tx_s_c = $signed({1'b0, tx_dly_r[TXY_DLY-1]});
  assign ctx_c  = 18'sd65536 - tx_s_c;
  assign ty_s_c = $signed({1'b0, ty_dly_r[TXY_DLY+1]});
  assign cty_c  = 18'sd65536 - ty_s_c;

  // bilinear blend, x then y
  always_ff @(posedge clk) begin
    bx0_r <= ctx_c * va_r;
    bx1_r <= tx_s_c * vb_r;
    bx2_r <= ctx_c * vc_r;
    bx3_r <= tx_s_c * vd_r;
    lx0_r <= 19'(rnd16(40'(bx0_r) + 40'(bx1_r)));
    lx1_r <= 19'(rnd16(40'(bx2_r) + 40'(bx3_r)));
    by0_r <= cty_c * lx0_r;
    by1_r <= ty_s_c * lx1_r;
  end

  assign r_c = rnd16(40'(by0_r) + 40'(by1_r));

  // saturate to plus or minus one
  always_ff @(posedge clk) begin
    if (r_c > 24'sd65536) res_r <= 18'sd65536;
    else if (r_c < -24'sd65536) res_r <= -18'sd65536;
    else res_r <= 18'(r_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) post_vld_r[i] <= 1'b0;
    end else begin
      post_vld_r[0] <= gv_c[0] & gv_c[1] & gv_c[2] & gv_c[3];
      for (int i = 1; i < 6; i++) post_vld_r[i] <= post_vld_r[i-1];
    end
  end

  assign out_valid       = post_vld_r[5];
  assign out_noise_value = res_r;

endmodule

FILE: tb/tileable_gradient_noise_2d_tb.sv
`timescale 1ns / 1ps

module tileable_gradient_noise_2d_tb;
  import tgn_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        in_coord_x = '0;
  logic [31:0]        in_coord_y = '0;
  logic               out_valid;
  logic signed [17:0] out_noise_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [0:0]         cfg_index = '0;
  logic [2:0]         cfg_data = '0;

  sample_t            pending[$];
  logic signed [17:0] noise_due[$];
  longint             sin_lut[256];
  logic [2:0]         cur_tile_log2 = 3'd3;
  logic [1:0]         cur_fade = FADE_LINEAR;
  int                 fails = 0;
  int                 cycles = 0;
  int                 gap_left = 0;
  bit                 gaps_on = 1'b1;

  tileable_gradient_noise_2d dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Sine/cosine table: quarter wave by Taylor series in Q30, rounded to Q16
  function automatic longint quarter_sine(int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    x = (64'd3373259426 * 64'(r)) >> 7;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s -= longint'(t);
      else s += longint'(t);
    end
    if (s < 0) s = 0;
    s = (s + 8192) >> 14;
    return (s > ONE) ? ONE : s;
  endfunction

  function automatic longint round16(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 32768) >> 16;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 32-bit hash with arithmetic right shifts
  function automatic logic [31:0] hash32(logic [31:0] h);
    h = (h ^ 32'($signed(h) >>> 16)) * 32'h21f0aaad;
    h = (h ^ 32'($signed(h) >>> 15)) * 32'h735a2d97;
    return h ^ 32'($signed(h) >>> 15);
  endfunction

  function automatic void to_unit(inout longint vx, inout longint vy);
    longint m;
    m = floor_sqrt(vx * vx + vy * vy);
    if (m == 0) begin
      vx = 0;
      vy = 0;
    end else begin
      vx = div_near(vx * ONE, m);
      vy = div_near(vy * ONE, m);
    end
  endfunction

  function automatic void lattice_grad(logic [31:0] cx, logic [31:0] cy, int lg,
                                       output longint gx, output longint gy);
    logic [31:0] mask;
    logic [31:0] h1;
    logic [31:0] h2;
    int          sh;
    mask = (32'd1 << lg) - 32'd1;
    sh = 8 - lg;
    h1 = hash32((cx & mask) ^ hash32(cy & mask));
    h2 = hash32(h1);
    gx = sin_lut[(((h1 & mask) << sh) + 64) & 255];
    gy = sin_lut[((h2 & mask) << sh) & 255];
    to_unit(gx, gy);
    gx = 2 * gx - ONE;
    gy = 2 * gy - ONE;
    to_unit(gx, gy);
  endfunction

  function automatic longint fade_curve(longint t);
    longint t2;
    longint t3;
    longint r;
    if (cur_fade == FADE_CUBIC) begin
      t2 = round16(t * t);
      r = round16(t2 * (3 * ONE - 2 * t));
    end else if (cur_fade == FADE_POLY5) begin
      t2 = round16(t * t);
      t3 = round16(t2 * t);
      r = round16(t3 * (6 * t2 - 15 * t + 10 * ONE));
    end else begin
      r = t;
    end
    if (r < 0) r = 0;
    return (r > ONE) ? ONE : r;
  endfunction

  function automatic longint mix_lin(longint f0, longint f1, longint t);
    return round16((ONE - t) * f0 + t * f1);
  endfunction

  function automatic logic signed [17:0] predict_noise(sample_t s);
    logic [31:0] ix;
    logic [31:0] iy;
    longint      fx;
    longint      fy;
    longint      g[8];
    longint      va, vb, vc, vd, tx, ty, r;
    int          lg;
    ix = s.x >> 16;
    iy = s.y >> 16;
    fx = s.x[15:0];
    fy = s.y[15:0];
    lg = cur_tile_log2;
    if (lg < LG_MIN) lg = LG_MIN;
    if (lg > LG_MAX) lg = LG_MAX;
    lattice_grad(ix, iy, lg, g[0], g[1]);
    lattice_grad(ix + 1, iy, lg, g[2], g[3]);
    lattice_grad(ix, iy + 1, lg, g[4], g[5]);
    lattice_grad(ix + 1, iy + 1, lg, g[6], g[7]);
    va = round16(g[0] * fx + g[1] * fy);
    vb = round16(g[2] * (fx - ONE) + g[3] * fy);
    vc = round16(g[4] * fx + g[5] * (fy - ONE));
    vd = round16(g[6] * (fx - ONE) + g[7] * (fy - ONE));
    tx = fade_curve(fx);
    ty = fade_curve(fy);
    r = mix_lin(mix_lin(va, vb, tx), mix_lin(vc, vd, tx), ty);
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return 18'(r);
  endfunction

  // Driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (rst_n && start && !busy) noise_due.push_back(predict_noise({in_coord_x, in_coord_y}));
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending.size() > 0) begin
      sample_t s;
      s = pending.pop_front();
      in_coord_x <= s.x;
      in_coord_y <= s.y;
      start <= 1'b1;
      if (gaps_on) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: gap_left <= 0;
          6, 7, 8:          gap_left <= $urandom_range(1, 3);
          default:          gap_left <= $urandom_range(10, 40);
        endcase
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (noise_due.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, out_noise_value);
        fails++;
      end else begin
        logic signed [17:0] want;
        want = noise_due.pop_front();
        if (out_noise_value !== want) begin
          $display("%0t: noise_value expected %0d got %0d", $time, want, out_noise_value);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [2:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 1'b0) cur_tile_log2 = val;
    else cur_fade = val[1:0];
  endtask

  task automatic drain();
    do @(posedge clk); while (pending.size() > 0 || start || noise_due.size() > 0);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 5))
      0: s = {$urandom(), $urandom()};
      1: s = {16'($urandom_range(0, 130)), 16'($urandom()),
              16'($urandom_range(0, 130)), 16'($urandom())};
      2: s = {16'($urandom()), 16'hffff, 16'($urandom()), 16'h0000};
      3: s = {16'($urandom_range(0, 70)), 16'h8000, 16'($urandom()), 16'($urandom())};
      4: s = {32'($urandom_range(0, 3)) << 30 | 32'($urandom_range(0, 65535)), $urandom()};
      default: s = {16'($urandom_range(0, 10)), 16'($urandom_range(0, 255)),
                    16'($urandom_range(0, 10)), 16'($urandom_range(65280, 65535))};
    endcase
    return s;
  endfunction

  // Stimulus: directed corners at reset settings, then random phases
  initial begin
    logic [2:0] tiles[8] = '{3'd6, 3'd0, 3'd7, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6};
    logic [2:0] fades[8] = '{3'd2, 3'd1, 3'd3, 3'd5, 3'd0, 3'd2, 3'd6, 3'd1};
    for (int j = 0; j < 256; j++) begin
      int q;
      int r;
      q = (j >> 6) & 3;
      r = j & 63;
      sin_lut[j] = (q & 1) ? quarter_sine(64 - r) : quarter_sine(r);
      if (q & 2) sin_lut[j] = -sin_lut[j];
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    pending.push_back({32'h0, 32'h0});
    pending.push_back({32'hffffffff, 32'hffffffff});
    pending.push_back({32'hffffffff, 32'h0});
    pending.push_back({32'h0, 32'hffffffff});
    pending.push_back({32'h0000ffff, 32'h0000ffff});
    pending.push_back({32'h00008000, 32'h00008000});
    pending.push_back({32'h00070000, 32'h00070000});
    pending.push_back({32'h0007ffff, 32'h0007ffff});
    pending.push_back({32'h003fffff, 32'h003f8000});
    pending.push_back({32'h00010000, 32'h00000001});
    pending.push_back({32'haaaaaaaa, 32'h55555555});
    pending.push_back({32'h55555555, 32'haaaaaaaa});
    pending.push_back({32'h80000000, 32'h7fffffff});
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(1'b0, tiles[p]);
      write_reg(1'b1, fades[p]);
      gaps_on = (p != 3);
      pending.push_back({32'h0, 32'hffffffff});
      pending.push_back({32'hffff8000, 32'h00000000});
      for (int k = 0; k < 150; k++) pending.push_back(rand_sample());
      drain();
    end

    repeat (120) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
